FILE: hw/rtl/eiq_pkg.sv
// shared types and constants for the expiring input queue
// no dependencies; used by expiring_input_queue and its testbench
package eiq_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned ATK_W    = 4;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned CFG_W    = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd150;
  localparam logic [CAP_W-1:0]    CAP_RST    = 5'd10;

  // configuration register indexes
  localparam logic CFG_WINDOW   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_CONSUME = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_EXP_RD,
    S_EXP_CHK,
    S_CON_RD,
    S_CON_GET,
    S_PEEK,
    S_PEEK_GET,
    S_EMIT
  } state_e;

endpackage

FILE: hw/rtl/eiq_ram.sv
// entry store of the expiring input queue: one write port, one read port
// read data registered; depends on no package
module eiq_ram #(
  parameter int unsigned DATA_W = 52,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                    wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                    rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/expiring_input_queue.sv
// order: push, clear and tick pass through exec, then peek, then emit; a consume walks
// the expiry check from the head (read, check, drop each expired entry), then reads and
// hands out the next unconsumed entry, then peeks; peek reads the entry left to peek, if any
// throughput: one item at a time, the next beat is taken once the result is loaded into
// the output register; the expiry walk and any stall on the result hold the flow
// reset: queue empty, time zero, window 150 ticks, capacity 10; no memory clearing
module expiring_input_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [eiq_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // event_id, attack_type, zero fill
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_id, out_attack, pending, next_id, next_attack, zero fill
  output logic [0:0]  m_axis_tuser    // found
);

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned CMP_W   = (CNT_W > eiq_pkg::CAP_W) ? CNT_W : eiq_pkg::CAP_W;
  localparam int unsigned AGE_W   = (STAMP_BITS > eiq_pkg::WINDOW_W) ? STAMP_BITS
                                                                     : eiq_pkg::WINDOW_W;
  localparam int unsigned ID_W    = eiq_pkg::ID_W;
  localparam int unsigned ATK_W   = eiq_pkg::ATK_W;
  localparam int unsigned ENTRY_W = ID_W + ATK_W + STAMP_BITS;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  eiq_pkg::state_e state_q, state_d;
  eiq_pkg::kind_e  kind_q, kind_d;

  logic [eiq_pkg::WINDOW_W-1:0] window_q;
  logic [eiq_pkg::CAP_W-1:0]    cap_q;

  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      stored_q, stored_d;
  logic [CNT_W-1:0]      used_q, used_d;
  logic [STAMP_BITS-1:0] tick_q, tick_d;

  logic [ID_W-1:0]  id_q, id_d;
  logic [ATK_W-1:0] atk_q, atk_d;

  logic             found_q, found_d;
  logic [ID_W-1:0]  oid_q, oid_d;
  logic [ATK_W-1:0] oatk_q, oatk_d;
  logic             pend_q, pend_d;
  logic [ID_W-1:0]  nid_q, nid_d;
  logic [ATK_W-1:0] natk_q, natk_d;

  logic             m_valid_q, m_valid_d;
  logic             m_found_q, m_found_d;
  logic [ID_W-1:0]  m_oid_q, m_oid_d;
  logic [ATK_W-1:0] m_oatk_q, m_oatk_d;
  logic             m_pend_q, m_pend_d;
  logic [ID_W-1:0]  m_nid_q, m_nid_d;
  logic [ATK_W-1:0] m_natk_q, m_natk_d;

  // memory port
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic [ID_W-1:0]       rd_id;
  logic [ATK_W-1:0]      rd_atk;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic [STAMP_BITS-1:0] age;
  logic                  age_exp;

  // push bookkeeping: room for the new entry, then the capacity drop
  logic             drop1, drop2;
  logic [IDX_W-1:0] head1, push_head;
  logic [CNT_W-1:0] stored1, stored2, used1, push_used;
  logic [CMP_W-1:0] eff_cap;

  assign rd_id    = mem_rdata[ID_W-1:0];
  assign rd_atk   = mem_rdata[ID_W+ATK_W-1:ID_W];
  assign rd_stamp = mem_rdata[ENTRY_W-1:ID_W+ATK_W];
  assign age      = tick_q - rd_stamp;
  assign age_exp  = AGE_W'(age) > AGE_W'(window_q);

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  assign drop1     = (stored_q == DEPTH_C);
  assign head1     = drop1 ? ring_pos(head_q, ONE_C) : head_q;
  assign stored1   = drop1 ? stored_q - ONE_C : stored_q;
  assign used1     = (drop1 && used_q != '0) ? used_q - ONE_C : used_q;
  assign stored2   = stored1 + ONE_C;
  assign drop2     = CMP_W'(stored2) > eff_cap;
  assign push_head = drop2 ? ring_pos(head1, ONE_C) : head1;
  assign push_used = (drop2 && used1 != '0) ? used1 - ONE_C : used1;

  assign mem_waddr = ring_pos(head1, stored1);
  assign mem_wdata = {tick_q, atk_q, id_q};

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    id_d      = id_q;
    atk_d     = atk_q;
    head_d    = head_q;
    stored_d  = stored_q;
    used_d    = used_q;
    tick_d    = tick_q;
    found_d   = found_q;
    oid_d     = oid_q;
    oatk_d    = oatk_q;
    pend_d    = pend_q;
    nid_d     = nid_q;
    natk_d    = natk_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_found_d = m_found_q;
    m_oid_d   = m_oid_q;
    m_oatk_d  = m_oatk_q;
    m_pend_d  = m_pend_q;
    m_nid_d   = m_nid_q;
    m_natk_d  = m_natk_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = ring_pos(head_q, used_q);
    s_axis_tready = (state_q == eiq_pkg::S_IDLE);

    unique case (state_q)
      eiq_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = eiq_pkg::kind_e'(s_axis_tuser);
          id_d    = s_axis_tdata[ID_W-1:0];
          atk_d   = s_axis_tdata[ID_W+ATK_W-1:ID_W];
          state_d = eiq_pkg::S_EXEC;
        end
      end
      eiq_pkg::S_EXEC: begin
        found_d = 1'b0;
        oid_d   = '0;
        oatk_d  = '0;
        unique case (kind_q)
          eiq_pkg::KIND_PUSH: begin
            mem_we   = 1'b1;
            head_d   = push_head;
            stored_d = drop2 ? stored1 : stored2;
            used_d   = push_used;
            state_d  = eiq_pkg::S_PEEK;
          end
          eiq_pkg::KIND_CONSUME: begin
            state_d = eiq_pkg::S_EXP_RD;
          end
          eiq_pkg::KIND_CLEAR: begin
            head_d   = '0;
            stored_d = '0;
            used_d   = '0;
            state_d  = eiq_pkg::S_PEEK;
          end
          eiq_pkg::KIND_TICK: begin
            tick_d  = tick_q + STAMP_BITS'(1);
            state_d = eiq_pkg::S_PEEK;
          end
        endcase
      end
      eiq_pkg::S_EXP_RD: begin
        if (stored_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
          state_d   = eiq_pkg::S_EXP_CHK;
        end else begin
          state_d = eiq_pkg::S_CON_RD;
        end
      end
      eiq_pkg::S_EXP_CHK: begin
        if (age_exp) begin
          head_d   = ring_pos(head_q, ONE_C);
          stored_d = stored_q - ONE_C;
          if (used_q != '0) begin
            used_d = used_q - ONE_C;
          end
          state_d = eiq_pkg::S_EXP_RD;
        end else begin
          state_d = eiq_pkg::S_CON_RD;
        end
      end
      eiq_pkg::S_CON_RD: begin
        if (used_q < stored_q) begin
          mem_re  = 1'b1;
          state_d = eiq_pkg::S_CON_GET;
        end else begin
          state_d = eiq_pkg::S_PEEK;
        end
      end
      eiq_pkg::S_CON_GET: begin
        found_d = 1'b1;
        oid_d   = rd_id;
        oatk_d  = rd_atk;
        used_d  = used_q + ONE_C;
        state_d = eiq_pkg::S_PEEK;
      end
      eiq_pkg::S_PEEK: begin
        // read is issued in the state that follows any push write, so it sees the new entry
        if (used_q < stored_q) begin
          mem_re  = 1'b1;
          state_d = eiq_pkg::S_PEEK_GET;
        end else begin
          pend_d  = 1'b0;
          nid_d   = '0;
          natk_d  = '0;
          state_d = eiq_pkg::S_EMIT;
        end
      end
      eiq_pkg::S_PEEK_GET: begin
        pend_d  = 1'b1;
        nid_d   = rd_id;
        natk_d  = rd_atk;
        state_d = eiq_pkg::S_EMIT;
      end
      eiq_pkg::S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_found_d = found_q;
          m_oid_d   = oid_q;
          m_oatk_d  = oatk_q;
          m_pend_d  = pend_q;
          m_nid_d   = nid_q;
          m_natk_d  = natk_q;
          state_d   = eiq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = eiq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= eiq_pkg::S_IDLE;
      head_q    <= '0;
      stored_q  <= '0;
      used_q    <= '0;
      tick_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      stored_q  <= stored_d;
      used_q    <= used_d;
      tick_q    <= tick_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= eiq_pkg::WINDOW_RST;
      cap_q    <= eiq_pkg::CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        eiq_pkg::CFG_WINDOW:   window_q <= cfg_wdata_i[eiq_pkg::WINDOW_W-1:0];
        eiq_pkg::CFG_CAPACITY: cap_q    <= cfg_wdata_i[eiq_pkg::CAP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    id_q     <= id_d;
    atk_q    <= atk_d;
    found_q  <= found_d;
    oid_q    <= oid_d;
    oatk_q   <= oatk_d;
    pend_q   <= pend_d;
    nid_q    <= nid_d;
    natk_q   <= natk_d;
    m_found_q <= m_found_d;
    m_oid_q   <= m_oid_d;
    m_oatk_q  <= m_oatk_d;
    m_pend_q  <= m_pend_d;
    m_nid_q   <= m_nid_d;
    m_natk_q  <= m_natk_d;
  end

  eiq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {7'd0, m_natk_q, m_nid_q, m_pend_q, m_oatk_q, m_oid_q};

  // consumed entries are a prefix of the stored ones
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= stored_q)
    else $error("used count exceeds stored count");

  assert property (@(posedge clk_i) disable iff (!rst_ni) stored_q <= DEPTH_C)
    else $error("stored count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == eiq_pkg::S_EXEC))
    else $error("accepted beat not executed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eiq_pkg::S_EXEC && kind_q == eiq_pkg::KIND_CLEAR)
      |=> (stored_q == '0 && used_q == '0))
    else $error("clear left entries behind");

endmodule

FILE: test/tb_top.sv
// testbench for expiring_input_queue: random and directed push/consume/clear/tick beats
// checked against an in-bench model of the timestamped queue; needs eiq_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned MAX_CYCLE = 1_000_000;

  typedef struct {
    eiq_pkg::kind_e kind;
    logic [15:0]    id;
    logic [3:0]     atk;
    bit             drain;  // hold this beat back until every result is in
  } event_t;

  typedef struct {
    logic        found;
    logic [15:0] out_id;
    logic [3:0]  out_attack;
    logic        pending;
    logic [15:0] next_id;
    logic [3:0]  next_attack;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = eiq_pkg::CFG_WINDOW;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // event_id, attack_type, zero fill
  logic [1:0]  s_axis_tuser = eiq_pkg::KIND_TICK;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // out_id, out_attack, pending, next_id, next_attack, zero fill
  logic [0:0]  m_axis_tuser;        // found

  expiring_input_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // queue model
  // ---------------------------------------------------------------------------
  logic [15:0] ent_id    [SLOTS];
  logic [3:0]  ent_atk   [SLOTS];
  logic [31:0] ent_stamp [SLOTS];
  int unsigned head_pos   = 0;
  int unsigned fill       = 0;
  int unsigned taken      = 0;
  logic [31:0] now_tick   = '0;
  logic [15:0] window_reg = eiq_pkg::WINDOW_RST;
  logic [4:0]  cap_reg    = eiq_pkg::CAP_RST;

  function automatic int unsigned slot_at(int unsigned off);
    return (head_pos + off) % SLOTS;
  endfunction

  function automatic void drop_oldest();
    if (fill == 0) return;
    head_pos = (head_pos + 1) % SLOTS;
    fill--;
    if (taken > 0) taken--;
  endfunction

  function automatic verdict_t queue_step(eiq_pkg::kind_e kind, logic [15:0] id,
                                          logic [3:0] atk);
    verdict_t    v;
    int unsigned p;
    int unsigned lim;
    logic [31:0] age;
    v = '{default: '0};
    case (kind)
      eiq_pkg::KIND_PUSH: begin
        if (fill >= SLOTS) drop_oldest();
        p = slot_at(fill);
        ent_id[p]    = id;
        ent_atk[p]   = atk;
        ent_stamp[p] = now_tick;
        fill++;
        lim = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : cap_reg;
        if (fill > lim) drop_oldest();
      end
      eiq_pkg::KIND_CONSUME: begin
        // expired and consumed entries are both prefixes from the head
        while (fill > 0) begin
          age = now_tick - ent_stamp[slot_at(0)];
          if (age <= {16'd0, window_reg}) break;
          drop_oldest();
        end
        if (taken < fill) begin
          p = slot_at(taken);
          v.found      = 1'b1;
          v.out_id     = ent_id[p];
          v.out_attack = ent_atk[p];
          taken++;
        end
      end
      eiq_pkg::KIND_CLEAR: begin
        head_pos = 0;
        fill     = 0;
        taken    = 0;
      end
      default: now_tick = now_tick + 1;
    endcase
    if (taken < fill) begin
      p = slot_at(taken);
      v.pending     = 1'b1;
      v.next_id     = ent_id[p];
      v.next_attack = ent_atk[p];
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------------
  event_t      event_q[$];
  verdict_t    verdict_q[$];
  event_t      cur_event;
  int unsigned beats_in     = 0;
  int unsigned beats_out    = 0;
  int unsigned handed_out   = 0;
  int unsigned send_idle    = 0;
  int unsigned recv_stall   = 0;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;

  always @(posedge clk_i) begin : drive_blk
    verdict_t v;
    bit       hold;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        v = queue_step(cur_event.kind, cur_event.id, cur_event.atk);
        verdict_q.push_back(v);
        beats_in++;
      end
      hold = s_axis_tvalid && !s_axis_tready;
      if (!hold) begin
        if (event_q.size() > 0 && $urandom_range(99) >= send_idle &&
            (!event_q[0].drain || beats_in == beats_out)) begin
          cur_event = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'd0, cur_event.atk, cur_event.id};
          s_axis_tuser  <= cur_event.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : watch_blk
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out <= beats_out + 1;
      if (verdict_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %h",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (want.found) handed_out++;
        check_field("found",       16'(want.found),       16'(m_axis_tuser[0]));
        check_field("out_id",      want.out_id,           m_axis_tdata[15:0]);
        check_field("out_attack",  16'(want.out_attack),  16'(m_axis_tdata[19:16]));
        check_field("pending",     16'(want.pending),     16'(m_axis_tdata[20]));
        check_field("next_id",     want.next_id,          m_axis_tdata[36:21]);
        check_field("next_attack", 16'(want.next_attack), 16'(m_axis_tdata[40:37]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("[expiring_input_queue] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int unsigned queued    = 0;
  int unsigned drain_at  = 0;

  task automatic add_event(eiq_pkg::kind_e kind, logic [15:0] id, logic [3:0] atk);
    event_t e;
    e.kind  = kind;
    e.id    = id;
    e.atk   = atk;
    e.drain = (queued == drain_at);
    event_q.push_back(e);
    queued++;
  endtask

  task automatic add_random(eiq_pkg::kind_e kind);
    add_event(kind, 16'($urandom), 4'($urandom));
  endtask

  // sampled away from the active edge so the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || beats_in != beats_out);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    if (addr == eiq_pkg::CFG_WINDOW) window_reg = val;
    else cap_reg = val[4:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // bursts of pushes, aging ticks and consumes, with some clears and noise
  task automatic add_phase(int unsigned n, logic [15:0] win);
    int unsigned r;
    int unsigned k;
    int unsigned tick_hi;
    queued   = 0;
    drain_at = $urandom_range(n / 4, 3 * n / 4);
    tick_hi  = (win < 8) ? win + 2 : 5;
    while (queued < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        add_random(eiq_pkg::kind_e'($urandom_range(3)));
      end else if (r < 12) begin
        add_random(eiq_pkg::KIND_CLEAR);
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          add_random(eiq_pkg::KIND_PUSH);
          if ($urandom_range(99) < 30) add_random(eiq_pkg::KIND_TICK);
        end
        k = $urandom_range(0, tick_hi);
        repeat (k) add_random(eiq_pkg::KIND_TICK);
        k = $urandom_range(1, 4);
        repeat (k) add_random(eiq_pkg::KIND_CONSUME);
      end
    end
  endtask

  logic [15:0] phase_win [8] = '{16'd0, 16'd3, 16'd65535, 16'd5, 16'd2, 16'd1, 16'd10, 16'd150};
  logic [15:0] phase_cap [8] = '{16'd1, 16'd4, 16'd16, 16'd0, 16'd31, 16'd8, 16'd16, 16'd10};
  int unsigned idle_pct  [4] = '{0, 56, 0, 35};
  int unsigned stall_pct [4] = '{0, 0, 56, 35};

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain_at = 1000;

    // reset settings: empty consume, field extremes, ignored fields, clear
    add_event(eiq_pkg::KIND_CONSUME, 16'h0000, 4'h0);
    add_event(eiq_pkg::KIND_PUSH,    16'h0000, 4'h0);
    add_event(eiq_pkg::KIND_PUSH,    16'hFFFF, 4'hF);
    add_event(eiq_pkg::KIND_TICK,    16'hFFFF, 4'hF);
    add_event(eiq_pkg::KIND_CONSUME, 16'hAAAA, 4'h5);
    add_event(eiq_pkg::KIND_CLEAR,   16'h5555, 4'hA);
    add_event(eiq_pkg::KIND_CONSUME, 16'h0000, 4'h0);
    wait_idle();

    // small window and capacity: overflow drop, dropped consumed entry, partial expiry
    write_reg(eiq_pkg::CFG_WINDOW, 16'd1);
    write_reg(eiq_pkg::CFG_CAPACITY, 16'd3);
    add_event(eiq_pkg::KIND_PUSH,    16'h0001, 4'h1);
    add_event(eiq_pkg::KIND_PUSH,    16'h0002, 4'h2);
    add_event(eiq_pkg::KIND_PUSH,    16'h0003, 4'h3);
    add_event(eiq_pkg::KIND_PUSH,    16'h0004, 4'h4);
    add_event(eiq_pkg::KIND_CONSUME, 16'h0000, 4'h0);
    add_event(eiq_pkg::KIND_PUSH,    16'h0005, 4'h5);
    add_event(eiq_pkg::KIND_TICK,    16'h0000, 4'h0);
    add_event(eiq_pkg::KIND_PUSH,    16'h0006, 4'h6);
    add_event(eiq_pkg::KIND_TICK,    16'h0000, 4'h0);
    add_event(eiq_pkg::KIND_CONSUME, 16'h0000, 4'h0);
    add_event(eiq_pkg::KIND_CONSUME, 16'h0000, 4'h0);
    wait_idle();

    // fill deep, then lower the capacity under the fill
    write_reg(eiq_pkg::CFG_WINDOW, 16'd65535);
    write_reg(eiq_pkg::CFG_CAPACITY, 16'd16);
    for (int i = 0; i < 5; i++) add_random(eiq_pkg::KIND_PUSH);
    wait_idle();
    write_reg(eiq_pkg::CFG_CAPACITY, 16'd2);
    add_random(eiq_pkg::KIND_PUSH);
    add_random(eiq_pkg::KIND_CONSUME);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(eiq_pkg::CFG_WINDOW, phase_win[ph]);
      write_reg(eiq_pkg::CFG_CAPACITY, phase_cap[ph]);
      @(posedge clk_i);
      send_idle  <= idle_pct[ph % 4];
      recv_stall <= stall_pct[ph % 4];
      add_phase(240, phase_win[ph]);
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d results never arrived", verdict_q.size());
      errors++;
    end
    $display("ran %0d beats through eight register settings and four idle patterns,",
             beats_in);
    $display("%0d results checked, %0d entries handed out by consume", beats_out, handed_out);
    if (errors == 0) begin
      $display("[expiring_input_queue] OK");
    end else begin
      $display("[expiring_input_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/eiq_pkg.sv
hw/rtl/eiq_ram.sv
hw/rtl/expiring_input_queue.sv
test/tb_top.sv
